[src/tdlq_pkg.sv]
// ----------------------------------------------------------------------------
// tdlq_pkg
// Shared types and constants of the tail drop link queue: beat payloads,
// the stored packet descriptor, register map and operation codes.
// ----------------------------------------------------------------------------
package tdlq_pkg;

  // Descriptor store geometry.
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CountW     = 7;

  // Shared divider: one quotient bit per step.
  localparam int unsigned DivW     = 16;
  localparam int unsigned DivCntW  = $clog2(DivW + 1);

  // Configuration port.
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegLinkRate   = 2'd0;
  localparam logic [1:0] RegPropDelay  = 2'd1;
  localparam logic [1:0] RegBufferBytes = 2'd2;

  // Operation and packet kind codes.
  localparam logic       FuncEnqueue = 1'b0;
  localparam logic       FuncTxDone  = 1'b1;
  localparam logic [1:0] KindData    = 2'd0;
  localparam logic [1:0] KindAck     = 2'd1;

  typedef struct packed {
    logic        func;
    logic [15:0] pkt_tag;
    logic [15:0] pkt_size;
    logic [1:0]  pkt_kind;
    logic [7:0]  next_node;
    logic [7:0]  final_dst;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic              start_send;
    logic [16:0]       send_delay;
    logic              delivered;
    logic [15:0]       out_tag;
    logic [7:0]        out_node;
    logic [23:0]       bytes_queued;
    logic [CountW-1:0] data_count;
    logic [CountW-1:0] ack_count;
    logic [CountW-1:0] queued_count;
    logic [31:0]       drop_count;
    logic [47:0]       sent_total;
  } out_t;

  // One entry of the descriptor store (50 bits).
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] size;
    logic [1:0]  kind;
    logic [7:0]  node;
    logic [7:0]  dst;
  } desc_t;

endpackage

[src/tdlq_div.sv]
// ----------------------------------------------------------------------------
// tdlq_div
// Iterative restoring divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module tdlq_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tdlq_pkg::DivW-1:0]    dividend_i,
  input  logic [tdlq_pkg::DivW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [tdlq_pkg::DivW-1:0]    quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [tdlq_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic [tdlq_pkg::DivW-1:0]         rem_q, rem_d;
  logic [tdlq_pkg::DivW-1:0]         quo_q, quo_d;
  logic [tdlq_pkg::DivW-1:0]         dvs_q, dvs_d;
  logic [tdlq_pkg::DivW:0]           shifted;
  logic [tdlq_pkg::DivW+1:0]         trial;

  assign shifted = {rem_q, quo_q[tdlq_pkg::DivW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // Keep the partial remainder when the trial subtraction goes negative.
      if (!trial[tdlq_pkg::DivW+1]) begin
        rem_d = trial[tdlq_pkg::DivW-1:0];
        quo_d = {quo_q[tdlq_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[tdlq_pkg::DivW-1:0];
        quo_d = {quo_q[tdlq_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tdlq_pkg::DivCntW'(tdlq_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/tdlq_store.sv]
// ----------------------------------------------------------------------------
// tdlq_store
// Descriptor store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tdlq_store (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [tdlq_pkg::PtrW-1:0]   wr_addr_i,
  input  tdlq_pkg::desc_t             wr_data_i,
  input  logic                        rd_en_i,
  input  logic [tdlq_pkg::PtrW-1:0]   rd_addr_i,
  output tdlq_pkg::desc_t             rd_data_o
);

  tdlq_pkg::desc_t mem_q [tdlq_pkg::QueueDepth];
  tdlq_pkg::desc_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/tail_drop_link_queue.sv]
// ----------------------------------------------------------------------------
// tail_drop_link_queue
// Link packet queue with a byte budget and tail drop. Enqueue beats store
// packet descriptors, transmit-done beats pop the head and schedule the next
// transmission.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   in        sink       in_valid/in_ready   tdlq_pkg::in_t (func, descriptor)
//   out       source     out_valid/out_ready tdlq_pkg::out_t (one per input)
//   apb       slave      psel/penable/pready link_rate, prop_delay, buffer_bytes
//
// An enqueue that starts a transmission latches the beat, decides and
// writes the store, runs the shared divider (size / link_rate) and then
// loads the result register. A drop or an enqueue behind a busy head only
// latches, decides and loads the result; a pop that schedules the next
// head makes two store reads, then uses the divider. Input is accepted
// only in the idle state; a result waits in its own register while the
// next beat is latched and processed. Reset is asynchronous and clears
// all counters and pointers; the store needs no clearing pass since only
// written entries are ever read.
//
module tail_drop_link_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input beats.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tdlq_pkg::in_t                 in_data_i,
  // Result beats.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tdlq_pkg::out_t                out_data_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdlq_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input beat
  localparam logic [2:0] S_EXEC = 3'd1;  // decide, write store or start head read
  localparam logic [2:0] S_POP  = 3'd2;  // head descriptor available
  localparam logic [2:0] S_NEXT = 3'd3;  // new head descriptor available
  localparam logic [2:0] S_DIV  = 3'd4;  // waiting for the divider
  localparam logic [2:0] S_FIN  = 3'd5;  // load the result register

  localparam int unsigned PtrW   = tdlq_pkg::PtrW;
  localparam int unsigned CountW = tdlq_pkg::CountW;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] nxt;
    if (ptr == PtrW'(tdlq_pkg::QueueDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  // Configuration registers.
  logic [15:0] link_rate_q;
  logic [15:0] prop_delay_q;
  logic [23:0] buffer_bytes_q;
  logic        cfg_write;

  // Sequencer and queue state.
  logic [2:0]        state_q, state_d;
  tdlq_pkg::in_t     item_q, item_d;
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [CountW-1:0] count_q, count_d;
  logic [23:0]       occ_q, occ_d;
  logic [CountW-1:0] data_q, data_d;
  logic [CountW-1:0] ack_q, ack_d;
  logic [31:0]       drop_q, drop_d;
  logic [47:0]       sent_q, sent_d;

  // Per-beat result fields.
  logic        acc_q, acc_d;
  logic        start_q, start_d;
  logic [16:0] delay_q, delay_d;
  logic        deliv_q, deliv_d;
  logic [15:0] otag_q, otag_d;
  logic [7:0]  onode_q, onode_d;
  logic        add_prop_q, add_prop_d;

  // Result register.
  logic           out_valid_q, out_valid_d;
  tdlq_pkg::out_t out_q, out_d;

  // Store and divider hookup.
  logic              wr_en;
  tdlq_pkg::desc_t   wr_data;
  logic              rd_en;
  logic [PtrW-1:0]   rd_addr;
  tdlq_pkg::desc_t   rd_data;
  logic              div_start;
  logic [15:0]       div_dividend;
  logic [15:0]       div_divisor;
  logic              div_done;
  logic [15:0]       div_quotient;

  // Enqueue admission.
  logic        q_empty;
  logic        q_full;
  logic        fits;
  logic [24:0] occ_plus;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_rate_q    <= 16'd1;
      prop_delay_q   <= 16'd0;
      buffer_bytes_q <= 24'd65536;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        tdlq_pkg::RegLinkRate:    link_rate_q    <= pwdata[15:0];
        tdlq_pkg::RegPropDelay:   prop_delay_q   <= pwdata[15:0];
        tdlq_pkg::RegBufferBytes: buffer_bytes_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tdlq_pkg::RegLinkRate:    prdata = {16'd0, link_rate_q};
      tdlq_pkg::RegPropDelay:   prdata = {16'd0, prop_delay_q};
      tdlq_pkg::RegBufferBytes: prdata = {8'd0, buffer_bytes_q};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared units.
  // --------------------------------------------------------------------------
  tdlq_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // A link rate of zero behaves as one byte per tick.
  assign div_divisor = (link_rate_q == 16'd0) ? 16'd1 : link_rate_q;

  tdlq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // --------------------------------------------------------------------------
  // Admission check. An empty queue takes any packet; a full store drops even
  // when the bytes would fit.
  // --------------------------------------------------------------------------
  assign q_empty  = (count_q == '0);
  assign q_full   = (count_q >= CountW'(tdlq_pkg::QueueDepth));
  assign occ_plus = {1'b0, occ_q} + {9'd0, item_q.pkt_size};
  assign fits     = (occ_plus <= {1'b0, buffer_bytes_q});

  assign wr_data.tag  = item_q.pkt_tag;
  assign wr_data.size = item_q.pkt_size;
  assign wr_data.kind = item_q.pkt_kind;
  assign wr_data.node = item_q.next_node;
  assign wr_data.dst  = item_q.final_dst;

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    occ_d        = occ_q;
    data_d       = data_q;
    ack_d        = ack_q;
    drop_d       = drop_q;
    sent_d       = sent_q;
    acc_d        = acc_q;
    start_d      = start_q;
    delay_d      = delay_q;
    deliv_d      = deliv_q;
    otag_d       = otag_q;
    onode_d      = onode_q;
    add_prop_d   = add_prop_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    div_start    = 1'b0;
    div_dividend = item_q.pkt_size;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        acc_d      = 1'b0;
        start_d    = 1'b0;
        delay_d    = '0;
        deliv_d    = 1'b0;
        otag_d     = '0;
        onode_d    = '0;
        add_prop_d = 1'b0;
        state_d    = S_FIN;
        if (item_q.func == tdlq_pkg::FuncEnqueue) begin
          if (q_empty || (!q_full && fits)) begin
            wr_en   = 1'b1;
            tail_d  = next_ptr(tail_q);
            count_d = count_q + 1'b1;
            occ_d   = occ_plus[23:0];
            if (item_q.pkt_kind == tdlq_pkg::KindData) begin
              data_d = data_q + 1'b1;
            end else if (item_q.pkt_kind == tdlq_pkg::KindAck) begin
              ack_d = ack_q + 1'b1;
            end
            acc_d = 1'b1;
            if (q_empty) begin
              // First packet of an idle link: start its transmission.
              start_d   = 1'b1;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else if (drop_q != '1) begin
            drop_d = drop_q + 1'b1;
          end
        end else if (!q_empty) begin
          rd_en   = 1'b1;
          state_d = S_POP;
        end
      end

      S_POP: begin
        head_d  = next_ptr(head_q);
        count_d = count_q - 1'b1;
        occ_d   = (occ_q >= {8'd0, rd_data.size}) ? occ_q - {8'd0, rd_data.size} : '0;
        if (rd_data.kind == tdlq_pkg::KindData) begin
          if (data_q != '0) begin
            data_d = data_q - 1'b1;
          end
        end else if (rd_data.kind == tdlq_pkg::KindAck) begin
          if (ack_q != '0) begin
            ack_d = ack_q - 1'b1;
          end
        end
        sent_d  = sent_q + {32'd0, rd_data.size};
        deliv_d = 1'b1;
        otag_d  = rd_data.tag;
        onode_d = rd_data.node;
        if (count_q != CountW'(1)) begin
          // Fetch the new head to schedule its transmission.
          rd_en   = 1'b1;
          rd_addr = next_ptr(head_q);
          state_d = S_NEXT;
        end else begin
          state_d = S_FIN;
        end
      end

      S_NEXT: begin
        start_d      = 1'b1;
        add_prop_d   = (onode_q != rd_data.dst);
        div_dividend = rd_data.size;
        div_start    = 1'b1;
        state_d      = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          delay_d = {1'b0, div_quotient}
                  + (add_prop_q ? {1'b0, prop_delay_q} : 17'd0);
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.accepted     = acc_q;
          out_d.start_send   = start_q;
          out_d.send_delay   = delay_q;
          out_d.delivered    = deliv_q;
          out_d.out_tag      = otag_q;
          out_d.out_node     = onode_q;
          out_d.bytes_queued = occ_q;
          out_d.data_count   = data_q;
          out_d.ack_count    = ack_q;
          out_d.queued_count = count_q;
          out_d.drop_count   = drop_q;
          out_d.sent_total   = sent_q;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      occ_q       <= '0;
      data_q      <= '0;
      ack_q       <= '0;
      drop_q      <= '0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      occ_q       <= occ_d;
      data_q      <= data_d;
      ack_q       <= ack_d;
      drop_q      <= drop_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    acc_q      <= acc_d;
    start_q    <= start_d;
    delay_q    <= delay_d;
    deliv_q    <= deliv_d;
    otag_q     <= otag_d;
    onode_q    <= onode_d;
    add_prop_q <= add_prop_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The store never holds more descriptors than it has entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(tdlq_pkg::QueueDepth))
    else $error("queue count exceeds store depth");

  // Per-kind counters never exceed the total packet count.
  a_kind_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, data_q} + {1'b0, ack_q}) <= {1'b0, count_q})
    else $error("kind counters exceed queued count");

  // The divider only reports completion while the sequencer waits for it.
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  // Pointers agree with the count: equal pointers mean empty or full.
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == tail_q) |-> (count_q == '0 || count_q == CountW'(tdlq_pkg::QueueDepth)))
    else $error("pointers disagree with queue count");

  // A result never reports both an accepted enqueue and a delivery.
  a_out_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.accepted && out_q.delivered))
    else $error("result both accepted and delivered");

endmodule
